// File: rtl/acp_pkg.sv
// Shared types and character constants for the ANSI CSI sequence parser.
`timescale 1ns / 1ps

package acp_pkg;

    localparam int IDX_W   = 4;   // width of a result's parameter index
    localparam int CNT_W   = 5;   // width of the parameter count and total
    localparam int VAL_W   = 16;  // width of a result's parameter value
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;

    localparam int DEC_BASE = 10;

    typedef enum logic [2:0] {
        PM_START,
        PM_OPEN,
        PM_NUMBER,
        PM_AFTER_SEP,
        PM_DONE
    } parse_mode_t;

    typedef enum logic {
        CS_ACCEPT,
        CS_EMIT
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic             take;  // input item accepted this cycle
        logic             load;  // load result at idx into the output register
        logic [IDX_W-1:0] idx;
    } acp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_result;  // the offered item ends a sequence or reports end of input on an unfinished parse
        logic is_last;     // result at cmd.idx is the last of the run
    } acp_status_t;

endpackage

// File: rtl/ansi_csi_sequence_parser.sv
// Top level of the ANSI CSI sequence parser: controller plus datapath.
`timescale 1ns / 1ps

// Parses the body of an ANSI control sequence that follows ESC, one byte per
// input item: '[', optional decimal parameters separated by ';', and a final
// letter. An ordinary byte produces no result. A final letter produces one
// result per stored parameter (one result if there are none), and an
// end_of_input item on an unfinished parse produces one incomplete report;
// the sequencer moves such an item's results one result per cycle through the
// single output register, and stalls while m_ready is low. Input is not taken
// while results are being sequenced out. Parameter values saturate at
// 2^PARAM_BITS - 1; parameters beyond MAX_PARAMS are dropped and clear
// status_ok. s_start_new clears the parse before its own byte is used.
module ansi_csi_sequence_parser #(
    parameter int MAX_PARAMS = 8,
    parameter int PARAM_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [acp_pkg::BYTE_W-1:0]    s_in_byte,
    input  logic                          s_start_new,
    input  logic                          s_end_of_input,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [acp_pkg::BYTE_W-1:0]    m_final_letter,
    output logic [acp_pkg::IDX_W-1:0]     m_param_index,
    output logic [acp_pkg::VAL_W-1:0]     m_param_value,
    output logic [acp_pkg::CNT_W-1:0]     m_param_total,
    output logic                          m_status_ok,
    output logic                          m_complete,
    output logic                          m_last
);
    import acp_pkg::*;

    acp_cmd_t    cmd;
    acp_status_t status;

    acp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    acp_dpath #(
        .MAX_PARAMS (MAX_PARAMS),
        .PARAM_BITS (PARAM_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_in_byte      (s_in_byte),
        .s_start_new    (s_start_new),
        .s_end_of_input (s_end_of_input),
        .cmd            (cmd),
        .status         (status),
        .m_final_letter (m_final_letter),
        .m_param_index  (m_param_index),
        .m_param_value  (m_param_value),
        .m_param_total  (m_param_total),
        .m_status_ok    (m_status_ok),
        .m_complete     (m_complete),
        .m_last         (m_last)
    );

`ifndef SYNTH
    // never accept a byte while a result is being loaded
    a_take_load_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take && cmd.load))
        else $error("input accepted during result sequencing");

    a_incomplete_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_complete) |-> (m_last && !m_status_ok && m_final_letter == '0))
        else $error("malformed incomplete report");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_complete && m_param_total != '0) |->
        (CNT_W'(m_param_index) < m_param_total))
        else $error("parameter index beyond total");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && !status.is_last) |=> (m_valid && !m_last))
        else $error("last flag set early");
`endif

endmodule

// File: rtl/acp_ctrl.sv
// Handshake controller and result sequencer for the ANSI CSI sequence parser.
`timescale 1ns / 1ps

module acp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  acp_pkg::acp_status_t status,
    output acp_pkg::acp_cmd_t   cmd
);
    import acp_pkg::*;

    ctl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_ACCEPT;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_ready      = 1'b0;
        cmd.take     = 1'b0;
        cmd.load     = 1'b0;
        cmd.idx      = idx_reg;
        unique case (state_reg)
            CS_ACCEPT: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && status.has_result) begin
                    state_next = CS_EMIT;
                    idx_next   = '0;
                end
            end
            CS_EMIT: begin
                // advance one result each time the output register frees up
                cmd.load = out_free;
                if (out_free) begin
                    if (status.is_last) begin
                        state_next = CS_ACCEPT;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = CS_ACCEPT;
            end
        endcase

        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/acp_dpath.sv
// Parse state, parameter accumulator, parameter store and output register.
`timescale 1ns / 1ps

module acp_dpath #(
    parameter int MAX_PARAMS = 8,
    parameter int PARAM_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [acp_pkg::BYTE_W-1:0]    s_in_byte,
    input  logic                          s_start_new,
    input  logic                          s_end_of_input,
    input  acp_pkg::acp_cmd_t             cmd,
    output acp_pkg::acp_status_t          status,
    output logic [acp_pkg::BYTE_W-1:0]    m_final_letter,
    output logic [acp_pkg::IDX_W-1:0]     m_param_index,
    output logic [acp_pkg::VAL_W-1:0]     m_param_value,
    output logic [acp_pkg::CNT_W-1:0]     m_param_total,
    output logic                          m_status_ok,
    output logic                          m_complete,
    output logic                          m_last
);
    import acp_pkg::*;

    localparam int SEL_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int WIDE_W = PARAM_BITS + 4;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARAMS);

    parse_mode_t           mode_reg, mode_next, mode_e;
    logic                  ok_reg, ok_next, ok_e;
    logic [CNT_W-1:0]      count_reg, count_next, count_e;
    logic [BYTE_W-1:0]     letter_reg, letter_next, letter_e;
    logic                  incomplete_reg, incomplete_next;
    logic [PARAM_BITS-1:0] acc_reg, acc_next;
    logic [PARAM_BITS-1:0] store_reg [MAX_PARAMS];

    logic                  wr_en;
    logic                  legal;
    logic                  room;
    logic                  is_digit, is_letter;
    logic [3:0]            digit;
    logic [WIDE_W-1:0]     acc_wide, prod;
    logic [PARAM_BITS-1:0] acc_sat;
    logic [PARAM_BITS-1:0] rd_value;
    logic [VAL_W+PARAM_BITS-1:0] rd_ext;

    assign is_digit  = (s_in_byte >= CH_ZERO) && (s_in_byte <= CH_NINE);
    assign is_letter = ((s_in_byte >= CH_UPPER_A) && (s_in_byte <= CH_UPPER_Z)) ||
                       ((s_in_byte >= CH_LOWER_A) && (s_in_byte <= CH_LOWER_Z));
    assign digit     = 4'(s_in_byte - CH_ZERO);

    // acc * 10 + digit, saturated
    assign acc_wide = WIDE_W'(acc_reg);
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(digit);
    assign acc_sat  = (|prod[WIDE_W-1:PARAM_BITS]) ? {PARAM_BITS{1'b1}}
                                                   : prod[PARAM_BITS-1:0];

    always_comb begin
        // start_new clears the parse before the byte is looked at
        mode_e   = s_start_new ? PM_START : mode_reg;
        ok_e     = s_start_new ? 1'b1 : ok_reg;
        count_e  = s_start_new ? '0 : count_reg;
        letter_e = s_start_new ? '0 : letter_reg;
        room     = count_e < MAX_CNT;

        mode_next       = mode_e;
        ok_next         = ok_e;
        count_next      = count_e;
        letter_next     = letter_e;
        acc_next        = acc_reg;
        incomplete_next = incomplete_reg;
        wr_en           = 1'b0;
        legal           = 1'b0;
        status.has_result = 1'b0;
        status.is_last    = incomplete_reg || (count_reg == '0) ||
                            ((CNT_W'(cmd.idx) + CNT_W'(1)) == count_reg);

        if (s_end_of_input) begin
            if (mode_e != PM_DONE) begin
                ok_next           = 1'b0;
                incomplete_next   = 1'b1;
                status.has_result = 1'b1;
            end
        end else begin
            unique case (mode_e)
                PM_START: begin
                    if (s_in_byte == CH_LBRACKET) begin
                        legal     = 1'b1;
                        mode_next = PM_OPEN;
                    end
                end
                PM_OPEN, PM_AFTER_SEP: begin
                    if (is_digit) begin
                        legal     = 1'b1;
                        mode_next = PM_NUMBER;
                        if (room) begin
                            acc_next = PARAM_BITS'(digit);
                        end else begin
                            ok_next = 1'b0;
                        end
                    end else if (is_letter && mode_e == PM_OPEN) begin
                        legal       = 1'b1;
                        letter_next = s_in_byte;
                        mode_next   = PM_DONE;
                    end
                end
                PM_NUMBER: begin
                    if (is_digit) begin
                        legal = 1'b1;
                        if (room) begin
                            acc_next = acc_sat;
                        end
                    end else if (s_in_byte == CH_SEMI || is_letter) begin
                        legal = 1'b1;
                        // close the parameter; a dropped one is not stored
                        if (room) begin
                            wr_en      = 1'b1;
                            count_next = count_e + CNT_W'(1);
                        end
                        if (is_letter) begin
                            letter_next = s_in_byte;
                            mode_next   = PM_DONE;
                        end else begin
                            mode_next = PM_AFTER_SEP;
                        end
                    end
                end
                default: begin
                    legal = 1'b0;
                end
            endcase

            if (!legal) begin
                ok_next = 1'b0;
            end else if (mode_next == PM_DONE) begin
                incomplete_next   = 1'b0;
                status.has_result = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= PM_START;
            ok_reg         <= 1'b1;
            count_reg      <= '0;
            letter_reg     <= '0;
            incomplete_reg <= 1'b0;
        end else if (cmd.take) begin
            mode_reg       <= mode_next;
            ok_reg         <= ok_next;
            count_reg      <= count_next;
            letter_reg     <= letter_next;
            incomplete_reg <= incomplete_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            acc_reg <= acc_next;
        end
        if (cmd.take && wr_en) begin
            store_reg[count_e[SEL_W-1:0]] <= acc_reg;
        end
    end

    assign rd_value = store_reg[cmd.idx[SEL_W-1:0]];
    assign rd_ext   = {{VAL_W{1'b0}}, rd_value};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (incomplete_reg) begin
                m_final_letter <= '0;
                m_param_index  <= '0;
                m_param_value  <= '0;
                m_param_total  <= count_reg;
                m_status_ok    <= 1'b0;
                m_complete     <= 1'b0;
                m_last         <= 1'b1;
            end else if (count_reg == '0) begin
                m_final_letter <= letter_reg;
                m_param_index  <= '0;
                m_param_value  <= '0;
                m_param_total  <= '0;
                m_status_ok    <= ok_reg;
                m_complete     <= 1'b1;
                m_last         <= 1'b1;
            end else begin
                m_final_letter <= letter_reg;
                m_param_index  <= cmd.idx;
                m_param_value  <= rd_ext[VAL_W-1:0];
                m_param_total  <= count_reg;
                m_status_ok    <= ok_reg;
                m_complete     <= 1'b1;
                m_last         <= status.is_last;
            end
        end
    end

endmodule
